// File: src/gpna_pkg.sv
// Package: shared constants and functions of the Gaussian pixel noise adder.
package gpna_pkg;

	// Fixed point width of the log stage and the CORDIC step count.
	localparam int LOG_FRAC = 30;
	localparam int CORDIC_STEPS = 16;

	// Fixed constants of the noise math.
	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
	localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [7:0] GAIN_RESET = 8'd128;

	// Arctangent table in Q16, one entry per CORDIC step.
	function automatic logic [16:0] atan_q16(input logic [3:0] idx);
		logic [16:0] r;
		case (idx)
			4'd0: r = 17'd51472;
			4'd1: r = 17'd30386;
			4'd2: r = 17'd16055;
			4'd3: r = 17'd8150;
			4'd4: r = 17'd4091;
			4'd5: r = 17'd2047;
			4'd6: r = 17'd1024;
			4'd7: r = 17'd512;
			4'd8: r = 17'd256;
			4'd9: r = 17'd128;
			4'd10: r = 17'd64;
			4'd11: r = 17'd32;
			4'd12: r = 17'd16;
			4'd13: r = 17'd8;
			4'd14: r = 17'd4;
			default: r = 17'd2;
		endcase
		return r;
	endfunction

endpackage

// File: src/gpna_if.sv
// Interfaces: valid/ready channels of the Gaussian pixel noise adder.
interface gpna_in_if #(parameter int UNIFORM_BITS = 16);
	logic valid;
	logic ready;
	logic [7:0] pixel_in;
	logic [UNIFORM_BITS-1:0] uniform_a;
	logic [UNIFORM_BITS-1:0] uniform_b;
	modport source (output valid, pixel_in, uniform_a, uniform_b, input ready);
	modport sink (input valid, pixel_in, uniform_a, uniform_b, output ready);
endinterface

interface gpna_out_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_out;
	modport source (output valid, pixel_out, input ready);
	modport sink (input valid, pixel_out, output ready);
endinterface

interface gpna_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] noise_gain;
	modport source (output valid, noise_gain, input ready);
	modport sink (input valid, noise_gain, output ready);
endinterface

// File: src/gaussian_pixel_noise_adder_unit.sv
// Top level: Gaussian pixel noise adder with handshake channels.
// Usage:
//   din carries pixel_in, uniform_a and uniform_b; dout carries pixel_out;
//   cfg writes noise_gain (reset value 128); cfg.ready is high only while
//   no item is in flight.
//   One item is worked at a time. A fresh sample pair passes from acceptance
//   to dout.valid through a setup state, 30 log squarings on the shared
//   multiplier, one scaling multiply, the square root (start, 17 bit-serial
//   steps and the hand-off), the angle states, 16 CORDIC rotations, the
//   scaling states and the output register.
//   A spare item skips log and root.
//   din.ready is low from acceptance until the result leaves the output
//   register and rises the cycle after.
//   A stalled receiver holds pixel_out and blocks new items.
//   Reset clears the spare flag and restores gain to 128; the spare radius
//   and angle registers are undefined until the first fresh item writes them.
//   Results keep input order, exactly one per item.
module gaussian_pixel_noise_adder_unit #(
	parameter int UNIFORM_BITS = 16,
	parameter int SAMPLE_FRAC_BITS = 13
) (
	input logic clk,
	input logic arst_n,
	gpna_in_if.sink din,
	gpna_out_if.source dout,
	gpna_cfg_if.sink cfg
);
	import gpna_pkg::*;

	logic [7:0] gain_q;
	logic busy_q;
	logic out_valid_q;
	logic [7:0] out_q;
	logic core_done;
	logic [7:0] core_res;
	logic start;

	assign din.ready = !busy_q;
	assign start = din.valid && din.ready;
	assign cfg.ready = !busy_q;
	assign dout.valid = out_valid_q;
	assign dout.pixel_out = out_q;

	// Hold gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= GAIN_RESET;
		else if (cfg.valid && cfg.ready) gain_q <= cfg.noise_gain;
	end

	// Track busy and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) busy_q <= 1'b1;
			if (core_done) out_valid_q <= 1'b1;
			else if (out_valid_q && dout.ready) begin
				out_valid_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) out_q <= core_res;
	end

	gpna_core #(.UNIFORM_BITS(UNIFORM_BITS), .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .pixel(din.pixel_in),
		.ua(din.uniform_a), .ub(din.uniform_b), .gain(gain_q),
		.done(core_done), .result(core_res)
	);

`ifndef SYNTHESIS
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> busy_q) else $error("output without item");
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> !out_valid_q) else $error("result overwritten");
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("busy not set");
`endif
endmodule

// File: src/gpna_isqrt.sv
// Module: bit-serial integer square root, two radicand bits per cycle.
module gpna_isqrt #(
	parameter int IN_W = 64,
	parameter int OUT_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  radicand,
	output logic             done,
	output logic [OUT_W-1:0] root
);
	localparam int CW = $clog2(OUT_W + 1);

	logic [IN_W-1:0] rem_q;
	logic [IN_W-1:0] res_q;
	logic [IN_W-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [IN_W-1:0] trial;

	assign trial = res_q + bit_q;

	// Step one result bit per cycle, restoring form.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(OUT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= IN_W'(1) << (2 * OUT_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[OUT_W-1:0];
endmodule

// File: src/gpna_core.sv
// Module: sequencer with shared multiplier for the log and the CORDIC angle scaling.
module gpna_core #(
	parameter int UNIFORM_BITS = 16,
	parameter int SAMPLE_FRAC_BITS = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [7:0]              pixel,
	input  logic [UNIFORM_BITS-1:0] ua,
	input  logic [UNIFORM_BITS-1:0] ub,
	input  logic [7:0]              gain,
	output logic                    done,
	output logic [7:0]              result
);
	import gpna_pkg::*;

	localparam int RW = SAMPLE_FRAC_BITS + 3;
	localparam int EW = $clog2(UNIFORM_BITS + 2);
	localparam int SQ_IN = 2 * RW + 2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOGN = 4'd1;
	localparam logic [3:0] ST_LOGM = 4'd2;
	localparam logic [3:0] ST_VMUL = 4'd3;
	localparam logic [3:0] ST_SQS  = 4'd4;
	localparam logic [3:0] ST_SQW  = 4'd5;
	localparam logic [3:0] ST_ANG  = 4'd6;
	localparam logic [3:0] ST_ANGM = 4'd7;
	localparam logic [3:0] ST_CORD = 4'd8;
	localparam logic [3:0] ST_SMP  = 4'd9;
	localparam logic [3:0] ST_SMPM = 4'd10;
	localparam logic [3:0] ST_GAIN = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;

	logic [3:0] state_q;
	logic spare_q;
	logic use_sin_q;
	logic [RW-1:0] rad_q;
	logic [UNIFORM_BITS-1:0] ang_q;
	logic [RW-1:0] spare_rad_q;
	logic [UNIFORM_BITS-1:0] spare_ang_q;
	logic [7:0] pix_q;
	logic [4:0] cnt_q;
	logic [31:0] m_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [EW-1:0] e_q;
	logic [63:0] t_q;
	logic neg_q;
	logic zneg_q;
	logic signed [33:0] x_q, y_q;
	logic signed [18:0] z_q;
	logic signed [63:0] acc_q;

	// Shared multiplier, operands chosen by the sequencer.
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	always_comb begin
		mul_a = m_q;
		mul_b = m_q;
		case (state_q)
			ST_VMUL: begin
				mul_a = t_q[31:0];
				mul_b = {1'b0, TWO_LN2_Q30};
			end
			ST_ANGM: begin
				mul_a = t_q[31:0];
				mul_b = {15'd0, HALF_PI_Q16};
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// Leading one of the log argument.
	logic [UNIFORM_BITS:0] x_in;
	logic [EW-1:0] lead;
	assign x_in = {1'b0, ua} + 1'b1;
	always_comb begin
		lead = '0;
		for (int i = 0; i <= UNIFORM_BITS; i++)
			if (x_in[i]) lead = EW'(i);
	end

	// Square root unit.
	logic sq_start, sq_done;
	logic [SQ_IN-1:0] sq_arg;
	logic [RW:0] sq_root;
	gpna_isqrt #(.IN_W(SQ_IN), .OUT_W(RW + 1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_arg),
		.done(sq_done), .root(sq_root)
	);
	assign sq_start = (state_q == ST_SQS);
	always_comb begin
		if (2 * SAMPLE_FRAC_BITS >= 26)
			sq_arg = SQ_IN'(t_q << (2 * SAMPLE_FRAC_BITS - 26));
		else
			sq_arg = SQ_IN'(t_q >> (26 - 2 * SAMPLE_FRAC_BITS));
	end

	// CORDIC shifts.
	logic signed [33:0] dx, dy;
	assign dx = y_q >>> cnt_q[3:0];
	assign dy = x_q >>> cnt_q[3:0];
	logic [31:0] phase_u;
	assign phase_u = 32'(ang_q) << (32 - UNIFORM_BITS);
	logic signed [33:0] phase;
	assign phase = 34'(signed'(phase_u));
	logic signed [33:0] fold;
	always_comb begin
		if (phase > 34'sd1073741824) fold = phase - 34'sd2147483648;
		else if (phase < -34'sd1073741824) fold = phase + 34'sd2147483648;
		else fold = phase;
	end

	logic signed [63:0] total;
	logic signed [63:0] shr;
	assign total = acc_q + 64'(signed'({1'b0, pix_q})) * (64'sd1 <<< SAMPLE_FRAC_BITS)
		+ (64'sd1 <<< (SAMPLE_FRAC_BITS - 1));
	assign shr = total >>> SAMPLE_FRAC_BITS;

	// Sequence one item through log, sqrt, CORDIC and scaling; a spare item skips log and sqrt.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			spare_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) state_q <= spare_q ? ST_ANG : ST_LOGN;
				ST_LOGN: state_q <= ST_LOGM;
				ST_LOGM: if (cnt_q == 5'd29) state_q <= ST_VMUL;
				ST_VMUL: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_SQW;
				ST_SQW: if (sq_done) state_q <= ST_ANG;
				ST_ANG: state_q <= ST_ANGM;
				ST_ANGM: state_q <= ST_CORD;
				ST_CORD: if (cnt_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_SMP;
				ST_SMP: state_q <= ST_SMPM;
				ST_SMPM: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_FIN;
				ST_FIN: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					spare_q <= !spare_q;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				pix_q <= pixel;
				use_sin_q <= spare_q;
				rad_q <= spare_rad_q;
				ang_q <= spare_q ? spare_ang_q : ub;
				if (!spare_q) spare_ang_q <= ub;
				e_q <= lead;
				// Normalize to Q1.30, dropping low bits of a wide argument.
				if (int'(lead) <= LOG_FRAC)
					m_q <= 32'(64'(x_in) << (LOG_FRAC - int'(lead)));
				else
					m_q <= 32'(64'(x_in) >> (int'(lead) - LOG_FRAC));
				frac_q <= '0;
				cnt_q <= '0;
			end
			ST_LOGN: cnt_q <= '0;
			ST_LOGM: begin
				// Square the mantissa, take one log bit.
				if (prod[61]) begin
					m_q <= {1'b0, prod[61:31]};
					frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
				end else begin
					m_q <= prod[61:30];
					frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd29)
					t_q <= ((64'(UNIFORM_BITS) - 64'(e_q)) << LOG_FRAC)
						- 64'({frac_q[LOG_FRAC-2:0], prod[61]}) >> 6;
			end
			ST_VMUL: t_q <= prod >> 28;
			ST_SQW: if (sq_done) begin
				rad_q <= sq_root[RW-1:0];
				spare_rad_q <= sq_root[RW-1:0];
			end
			ST_ANG: begin
				neg_q <= (fold != phase);
				zneg_q <= fold[33];
				t_q <= 64'(fold[33] ? -fold : fold);
			end
			ST_ANGM: begin
				z_q <= zneg_q ? -19'(prod >> 30) : 19'(prod >> 30);
				x_q <= CORDIC_GAIN_Q30;
				y_q <= '0;
				cnt_q <= '0;
			end
			ST_CORD: begin
				// One CORDIC rotation per cycle.
				if (!z_q[18]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - 19'(atan_q16(cnt_q[3:0]));
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + 19'(atan_q16(cnt_q[3:0]));
				end
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SMP: begin
				acc_q <= 64'(signed'({1'b0, rad_q}))
					* 64'(neg_q ? -(use_sin_q ? y_q : x_q) : (use_sin_q ? y_q : x_q));
			end
			ST_SMPM: acc_q <= acc_q >>> 30;
			ST_GAIN: acc_q <= acc_q * 64'(signed'({1'b0, gain}));
			ST_FIN: begin
				if (shr < 0) result <= 8'd0;
				else if (shr > 64'sd255) result <= 8'd255;
				else result <= shr[7:0];
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE) else $error("done outside idle");
	a_spare_flip: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> spare_q != $past(spare_q)) else $error("spare not toggled");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOGN |-> $past(state_q) == ST_IDLE) else $error("bad entry");
`endif
endmodule
